[hw/rtl/affine_2d_matrix_stack_defines.svh]
// ============================================================================
// Assertion macros for the affine matrix stack
// Shared property forms used at the end of the stack modules. Each macro
// expects clk and rst_n to be visible where it is used.
// ============================================================================
`ifndef AFFINE_2D_MATRIX_STACK_DEFINES_SVH
`define AFFINE_2D_MATRIX_STACK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define A2MS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define A2MS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/a2ms_pkg.sv]
// ============================================================================
// a2ms_pkg
// Types, constants and decode functions shared by the matrix stack modules.
// ============================================================================
package a2ms_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 64;
    localparam int SUM_W       = 50;
    localparam int FRAC_W      = 16;

    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_ZERO = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_IDENTITY  = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_ROTATE    = 3'd3,
        OP_SCALE     = 3'd4,
        OP_PUSH      = 3'd5,
        OP_POP       = 3'd6,
        OP_POINT     = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PUSH_OVF = 2'd1,
        ST_POP_UNF  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CF_XX = 2'd0,
        CF_XY = 2'd1,
        CF_YX = 2'd2,
        CF_YY = 2'd3
    } coef_sel_t;

    typedef enum logic [1:0] {
        OS_A    = 2'd0,
        OS_B    = 2'd1,
        OS_ZERO = 2'd2
    } opnd_sel_t;

    typedef enum logic [1:0] {
        BS_NONE = 2'd0,
        BS_TX   = 2'd1,
        BS_TY   = 2'd2
    } base_sel_t;

    // One result: base + (c1*o1 >>> 16) +/- (c2*o2 >>> 16).
    typedef struct packed {
        coef_sel_t c1;
        opnd_sel_t o1;
        coef_sel_t c2;
        opnd_sel_t o2;
        logic      sub;
        base_sel_t base;
    } term_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] xx;
        logic signed [DATA_W-1:0] xy;
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] yx;
        logic signed [DATA_W-1:0] yy;
        logic signed [DATA_W-1:0] ty;
    } matrix_t;

    // Controller to datapath.
    typedef struct packed {
        logic        load;
        logic        mul_en;
        term_t       term;
        logic [1:0]  idx;
        logic        pop_read;
        logic        commit;
        opcode_t     op;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } stat_t;

    localparam matrix_t IDENTITY = '{xx: Q_ONE, xy: Q_ZERO, tx: Q_ZERO,
                                     yx: Q_ZERO, yy: Q_ONE, ty: Q_ZERO};

    // Index of the last result an opcode computes.
    function automatic logic [1:0] last_idx(opcode_t op);
        logic [1:0] n;
        unique case (op)
            OP_TRANSLATE, OP_POINT: n = 2'd1;
            OP_ROTATE, OP_SCALE:    n = 2'd3;
            default:                n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic has_mul(opcode_t op);
        return (op == OP_TRANSLATE) || (op == OP_POINT) ||
               (op == OP_ROTATE) || (op == OP_SCALE);
    endfunction

    // Operand selection for each result of each opcode.
    function automatic term_t term_spec(opcode_t op, logic [1:0] idx);
        term_t t;
        t = '{c1: CF_XX, o1: OS_ZERO, c2: CF_XX, o2: OS_ZERO, sub: 1'b0, base: BS_NONE};
        unique case (op)
            OP_TRANSLATE, OP_POINT:
            begin
                if (idx == 2'd0)
                    t = '{c1: CF_XX, o1: OS_A, c2: CF_XY, o2: OS_B, sub: 1'b0, base: BS_TX};
                else
                    t = '{c1: CF_YX, o1: OS_A, c2: CF_YY, o2: OS_B, sub: 1'b0, base: BS_TY};
            end
            OP_ROTATE:
            begin
                unique case (idx)
                    2'd0: t = '{c1: CF_XX, o1: OS_A, c2: CF_XY, o2: OS_B,
                                sub: 1'b0, base: BS_NONE};
                    2'd1: t = '{c1: CF_XY, o1: OS_A, c2: CF_XX, o2: OS_B,
                                sub: 1'b1, base: BS_NONE};
                    2'd2: t = '{c1: CF_YX, o1: OS_A, c2: CF_YY, o2: OS_B,
                                sub: 1'b0, base: BS_NONE};
                    default: t = '{c1: CF_YY, o1: OS_A, c2: CF_YX, o2: OS_B,
                                   sub: 1'b1, base: BS_NONE};
                endcase
            end
            OP_SCALE:
            begin
                unique case (idx)
                    2'd0: t.c1 = CF_XX;
                    2'd1: t.c1 = CF_YX;
                    2'd2: t.c1 = CF_XY;
                    default: t.c1 = CF_YY;
                endcase
                t.o1 = (idx[1]) ? OS_B : OS_A;
            end
            default:
            begin
                t.o1 = OS_ZERO;
            end
        endcase
        return t;
    endfunction

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            r = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

endpackage

[hw/rtl/a2ms_if.sv]
// ============================================================================
// Matrix stack channels
// Request and response channels with valid/ready handshakes.
// ============================================================================
interface a2ms_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface a2ms_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic [1:0]          status;
    logic [5:0]          depth;

    modport source (output valid, point_x, point_y, status, depth, input ready);
    modport sink   (input valid, point_x, point_y, status, depth, output ready);
endinterface

[hw/rtl/a2ms_ctrl.sv]
// ============================================================================
// a2ms_ctrl
// Sequencer: accepts a request word, steps the shared multipliers through
// the results of its opcode and commits once the response slot is free.
// ============================================================================
`include "affine_2d_matrix_stack_defines.svh"

module a2ms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_type,
    output a2ms_pkg::cmd_t      cmd,
    input  a2ms_pkg::stat_t     stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         idx_reg, idx_next;
    a2ms_pkg::opcode_t  op_reg, op_next;
    logic               accept;

    assign accept = in_valid && in_ready;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.idx      = idx_reg;
        cmd.term     = a2ms_pkg::term_spec(op_reg, idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = a2ms_pkg::opcode_t'(in_type);
                    idx_next   = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en   = a2ms_pkg::has_mul(op_reg);
                cmd.pop_read = (op_reg == a2ms_pkg::OP_POP);
                if (idx_reg == a2ms_pkg::last_idx(op_reg))
                    state_next = S_ACC;
                else
                    idx_next = idx_reg + 2'd1;
            end
            S_ACC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
            op_reg    <= a2ms_pkg::OP_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
        end
    end

    // An accepted word always starts the multiply sequence.
    `A2MS_ASSERT_NEXT(a_accept_to_mul, accept, state_reg == S_MUL, "accept did not start work")
    // The result index never runs past the last result of the opcode.
    `A2MS_ASSERT_SAME(a_idx_bound, state_reg == S_MUL,
        idx_reg <= a2ms_pkg::last_idx(op_reg), "result index out of range")
    // A commit only happens with a free response slot.
    `A2MS_ASSERT_SAME(a_commit_free, cmd.commit, stat.out_free, "commit into busy slot")

endmodule

[hw/rtl/a2ms_datapath.sv]
// ============================================================================
// a2ms_datapath
// Top matrix registers, stack memory, two shared multipliers with a
// saturating accumulate stage, and the response register.
// ============================================================================
`include "affine_2d_matrix_stack_defines.svh"

module a2ms_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  a2ms_pkg::cmd_t      cmd,
    output a2ms_pkg::stat_t     stat,
    input  logic signed [31:0]  in_a,
    input  logic signed [31:0]  in_b,
    a2ms_rsp_if.source          rsp
);

    localparam int LW = a2ms_pkg::LEVEL_W;
    localparam logic [LW-1:0] LEVEL_TOP = LW'(a2ms_pkg::STACK_DEPTH - 1);

    a2ms_pkg::matrix_t                      top_reg;
    a2ms_pkg::matrix_t                      mem [a2ms_pkg::STACK_DEPTH];
    a2ms_pkg::matrix_t                      mem_rd_reg;
    logic [LW-1:0]                          level_reg;
    logic signed [a2ms_pkg::DATA_W-1:0]     a_reg, b_reg;
    logic signed [a2ms_pkg::PROD_W-1:0]     p1_reg, p2_reg;
    logic signed [a2ms_pkg::DATA_W-1:0]     base_reg;
    logic                                   sub_reg;
    logic                                   acc_vld_reg;
    logic [1:0]                             acc_idx_reg;
    logic signed [a2ms_pkg::DATA_W-1:0]     res_reg [4];
    logic                                   out_vld_reg;
    logic signed [a2ms_pkg::DATA_W-1:0]     px_reg, py_reg;
    a2ms_pkg::status_t                      status_reg;
    logic [LW-1:0]                          depth_reg;

    logic                                   lvl_zero, lvl_full;
    logic signed [a2ms_pkg::DATA_W-1:0]     c1v, o1v, c2v, o2v, basev;
    logic signed [a2ms_pkg::SUM_W-1:0]      t1, t2, tb, sum;

    assign lvl_zero     = (level_reg == '0);
    assign lvl_full     = (level_reg == LEVEL_TOP);
    assign stat.out_free = !out_vld_reg || rsp.ready;

    // Operand selection for the multipliers.
    function automatic logic signed [31:0] pick_coef(a2ms_pkg::matrix_t m,
                                                     a2ms_pkg::coef_sel_t s);
        logic signed [31:0] v;
        unique case (s)
            a2ms_pkg::CF_XX: v = m.xx;
            a2ms_pkg::CF_XY: v = m.xy;
            a2ms_pkg::CF_YX: v = m.yx;
            default:         v = m.yy;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pick_opnd(logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     a2ms_pkg::opnd_sel_t s);
        logic signed [31:0] v;
        unique case (s)
            a2ms_pkg::OS_A: v = a;
            a2ms_pkg::OS_B: v = b;
            default:        v = a2ms_pkg::Q_ZERO;
        endcase
        return v;
    endfunction

    always_comb
    begin
        c1v = pick_coef(top_reg, cmd.term.c1);
        c2v = pick_coef(top_reg, cmd.term.c2);
        o1v = pick_opnd(a_reg, b_reg, cmd.term.o1);
        o2v = pick_opnd(a_reg, b_reg, cmd.term.o2);
        unique case (cmd.term.base)
            a2ms_pkg::BS_TX: basev = top_reg.tx;
            a2ms_pkg::BS_TY: basev = top_reg.ty;
            default:         basev = a2ms_pkg::Q_ZERO;
        endcase
    end

    // Accumulate stage: floor-shifted products plus base, summed exactly.
    always_comb
    begin
        t1  = a2ms_pkg::SUM_W'(p1_reg >>> a2ms_pkg::FRAC_W);
        t2  = a2ms_pkg::SUM_W'(p2_reg >>> a2ms_pkg::FRAC_W);
        tb  = a2ms_pkg::SUM_W'(base_reg);
        sum = sub_reg ? (tb + t1 - t2) : (tb + t1 + t2);
    end

    // Operand capture, multiply stage and accumulate stage.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= in_a;
            b_reg <= in_b;
        end
        if (cmd.mul_en)
        begin
            p1_reg      <= c1v * o1v;
            p2_reg      <= c2v * o2v;
            base_reg    <= basev;
            sub_reg     <= cmd.term.sub;
            acc_idx_reg <= cmd.idx;
        end
        if (acc_vld_reg)
            res_reg[acc_idx_reg] <= a2ms_pkg::sat32(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_vld_reg <= 1'b0;
        else
            acc_vld_reg <= cmd.mul_en;
    end

    // Stack memory: push saves the top, pop reads the level below.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (cmd.op == a2ms_pkg::OP_PUSH) && !lvl_full)
            mem[level_reg] <= top_reg;
        if (cmd.pop_read)
            mem_rd_reg <= mem[LW'(level_reg - 1'b1)];
    end

    // Commit of the top matrix, the level and the response word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= a2ms_pkg::IDENTITY;
            level_reg   <= '0;
            out_vld_reg <= 1'b0;
            status_reg  <= a2ms_pkg::ST_OK;
            depth_reg   <= '0;
            px_reg      <= a2ms_pkg::Q_ZERO;
            py_reg      <= a2ms_pkg::Q_ZERO;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
            status_reg  <= a2ms_pkg::ST_OK;
            depth_reg   <= level_reg;
            px_reg      <= a2ms_pkg::Q_ZERO;
            py_reg      <= a2ms_pkg::Q_ZERO;
            unique case (cmd.op)
                a2ms_pkg::OP_CLEAR:
                begin
                    top_reg   <= a2ms_pkg::IDENTITY;
                    level_reg <= '0;
                    depth_reg <= '0;
                end
                a2ms_pkg::OP_IDENTITY:
                begin
                    top_reg <= a2ms_pkg::IDENTITY;
                end
                a2ms_pkg::OP_TRANSLATE:
                begin
                    top_reg.tx <= res_reg[0];
                    top_reg.ty <= res_reg[1];
                end
                a2ms_pkg::OP_ROTATE:
                begin
                    top_reg.xx <= res_reg[0];
                    top_reg.xy <= res_reg[1];
                    top_reg.yx <= res_reg[2];
                    top_reg.yy <= res_reg[3];
                end
                a2ms_pkg::OP_SCALE:
                begin
                    top_reg.xx <= res_reg[0];
                    top_reg.yx <= res_reg[1];
                    top_reg.xy <= res_reg[2];
                    top_reg.yy <= res_reg[3];
                end
                a2ms_pkg::OP_PUSH:
                begin
                    if (lvl_full)
                        status_reg <= a2ms_pkg::ST_PUSH_OVF;
                    else
                    begin
                        level_reg <= level_reg + 1'b1;
                        depth_reg <= level_reg + 1'b1;
                    end
                end
                a2ms_pkg::OP_POP:
                begin
                    if (lvl_zero)
                        status_reg <= a2ms_pkg::ST_POP_UNF;
                    else
                    begin
                        top_reg   <= mem_rd_reg;
                        level_reg <= level_reg - 1'b1;
                        depth_reg <= level_reg - 1'b1;
                    end
                end
                default:
                begin
                    px_reg <= res_reg[0];
                    py_reg <= res_reg[1];
                end
            endcase
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.point_x = px_reg;
    assign rsp.point_y = py_reg;
    assign rsp.status  = status_reg;
    assign rsp.depth   = 6'(depth_reg);

    // A pop on an empty stack leaves the level at zero.
    `A2MS_ASSERT_NEXT(a_pop_empty, cmd.commit && (cmd.op == a2ms_pkg::OP_POP) && lvl_zero,
        (level_reg == '0) && (status_reg == a2ms_pkg::ST_POP_UNF), "pop underflow mishandled")
    // A push on a full stack leaves the level at the top.
    `A2MS_ASSERT_NEXT(a_push_full, cmd.commit && (cmd.op == a2ms_pkg::OP_PUSH) && lvl_full,
        (level_reg == LEVEL_TOP) && (status_reg == a2ms_pkg::ST_PUSH_OVF),
        "push overflow mishandled")
    // The reported depth always matches the committed level.
    `A2MS_ASSERT_NEXT(a_depth_match, cmd.commit, depth_reg == level_reg,
        "reported depth differs from level")

endmodule

[hw/rtl/affine_2d_matrix_stack.sv]
// ============================================================================
// affine_2d_matrix_stack
// Command-driven stack of 2x3 Q16.16 affine matrices with point transform.
//
//   Channel | Dir | Fields
//   --------+-----+---------------------------------------------
//   req     | in  | req_type[2:0], operand_a[31:0], operand_b[31:0]
//   rsp     | out | point_x[31:0], point_y[31:0], status[1:0], depth[5:0]
//
// One word is in work at a time. A word is accepted, then for translate,
// point transform, rotate and scale two shared 32x32 multipliers produce
// one result per cycle; then the results are accumulated and the word is
// committed.
// The response register lets a new word be accepted while the last response
// waits; commit stalls while that register is still full and not taken.
// Reset sets the top matrix to identity at depth zero; no clearing pass.
// ============================================================================
module affine_2d_matrix_stack (
    input  logic        clk,
    input  logic        rst_n,
    a2ms_req_if.sink    req,
    a2ms_rsp_if.source  rsp
);

    a2ms_pkg::cmd_t   cmd;
    a2ms_pkg::stat_t  stat;

    a2ms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_type  (req.req_type),
        .cmd      (cmd),
        .stat     (stat)
    );

    a2ms_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .in_a  (req.operand_a),
        .in_b  (req.operand_b),
        .rsp   (rsp)
    );

endmodule
